### rtl/tspf_pkg.sv
// Shared types, constants and codes of the timed slot pool.
package tspf_pkg;

    localparam int POOL_SLOTS_DEF = 64;
    localparam int SLOT_W         = 6;
    localparam logic [31:0] DRAW_ONCE_MS = 32'd100;

    localparam logic KIND_SPAWN = 1'b0;
    localparam logic KIND_SWEEP = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [31:0] now_ms;
        logic [15:0] life_ms;
        logic [15:0] fade_ms;
        logic [7:0]  red_in;
        logic [7:0]  green_in;
        logic [7:0]  blue_in;
        logic [7:0]  alpha_in;
    } t_in;

    typedef struct packed {
        logic              result_kind;
        logic [SLOT_W-1:0] slot;
        logic              evicted;
        logic [7:0]        red_out;
        logic [7:0]        green_out;
        logic [7:0]        blue_out;
        logic [7:0]        alpha_out;
        logic              last;
    } t_out;

    // per-slot record, colour byte 0 is red
    typedef struct packed {
        logic            draw;
        logic [15:0]     flen;
        logic [31:0]     fstart;
        logic [31:0]     death;
        logic [3:0][7:0] colour;
    } t_slot_rec;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SP_LINK,
        ST_SW_RD,
        ST_SW_EVAL,
        ST_SW_DSTART,
        ST_SW_DWAIT,
        ST_SW_PUSH,
        ST_FLUSH
    } t_state;

endpackage

### rtl/tspf_ram.sv
// Generic single write port RAM with registered read.
module tspf_ram #(
    parameter int W = 8,
    parameter int D = 64
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/tspf_fade_div.sv
// Fade scaler: colour * remaining / length, one quotient bit per cycle.
module tspf_fade_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [7:0]  i_colour,
    input  logic [15:0] i_rem,
    input  logic [15:0] i_len,
    output logic        o_done,
    output logic [7:0]  o_quot
);
    logic [23:0] r_prod;
    logic [15:0] r_acc;
    logic [7:0]  r_q;
    logic [2:0]  r_cnt;
    logic        r_busy;
    logic        r_first;
    logic        r_done;
    logic [16:0] trial;
    logic        qbit;

    // rem < len, so the product's top 16 bits are already below len
    assign trial = {r_acc, r_q[7]};
    assign qbit  = (trial >= {1'b0, i_len});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_first <= 1'b0;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_first <= 1'b1;
                r_cnt   <= '0;
            end else if (r_busy && r_first) begin
                r_first <= 1'b0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd7) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_prod <= 24'(i_colour) * 24'(i_rem);
        end else if (r_busy && r_first) begin
            r_acc <= r_prod[23:8];
            r_q   <= r_prod[7:0];
        end else if (r_busy) begin
            r_acc <= qbit ? 16'(trial - {1'b0, i_len}) : trial[15:0];
            r_q   <= {r_q[6:0], qbit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

### rtl/timed_slot_pool_with_fade_core.sv
// Timed slot pool: age-ordered live list, free chain, fading sweep.
//
// Input channel (i_in_valid / o_in_stall, payload i_in_data) takes spawn and
// sweep items; output channel (o_out_valid / i_out_stall, o_out_data)
// returns results, each sweep's final one flagged by last.
// One item is in work at a time; o_in_stall is high from the transfer
// until the item's last result is loaded into the output register.
// Spawn: gives a single result.
// Sweep: expired slots and unfaded survivors pass without the scaler; each
// fading survivor waits while the one shared scaler runs four channels in turn
// (multiply, then 8 restoring divide steps each). An empty sweep gives
// no result.
// The slot records, links and free chain sit in registered-read RAMs with
// one read and one write per cycle; fresh slots are handed out by a
// counter, so no clearing pass is needed after reset.
// Reset empties the pool and drops any held result. When the receiver
// stalls, the result holds in the output register and the sweep waits with
// at most one further survivor held back.
module timed_slot_pool_with_fade_core #(
    parameter int POOL_SLOTS = tspf_pkg::POOL_SLOTS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  tspf_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output tspf_pkg::t_out o_out_data
);
    localparam int AW = $clog2(POOL_SLOTS);
    localparam int CW = $clog2(POOL_SLOTS + 1);
    localparam int RW = $bits(tspf_pkg::t_slot_rec);

    tspf_pkg::t_state r_state, n_state;
    tspf_pkg::t_in    r_item, n_item;
    tspf_pkg::t_out   r_pend, n_pend, r_out, n_out;
    logic             r_pend_vld, n_pend_vld, r_out_vld, n_out_vld;
    logic [AW-1:0]    r_slot, n_slot, r_cur, n_cur, r_head, n_head;
    logic [AW-1:0]    r_oldest, n_oldest, r_newest, n_newest;
    logic [CW-1:0]    r_count, n_count, r_fresh, n_fresh;
    logic             r_empty, n_empty, r_ev, n_ev, r_end, n_end;
    logic [15:0]      r_rem, n_rem, r_len, n_len;
    logic [3:0][7:0]  r_col, n_col;
    logic [1:0]       r_ch, n_ch;

    logic          nw_we, ol_we, fr_we, sr_we;
    logic [AW-1:0] nw_waddr, nw_wdata, nw_raddr, nw_rdata;
    logic [AW-1:0] ol_waddr, ol_wdata, ol_rdata;
    logic [AW-1:0] fr_waddr, fr_wdata, fr_rdata;
    logic [AW-1:0] sr_waddr;
    tspf_pkg::t_slot_rec sr_wdata, sr_rdata, spawn_rec;

    logic        out_free, is_old, is_new, do_link, scale;
    logic [15:0] fade_cap;
    logic [31:0] rem_full;
    logic        div_done;
    logic [7:0]  div_q;

    assign out_free = !r_out_vld || !i_out_stall;

    tspf_ram #(.W(AW), .D(POOL_SLOTS)) u_newer (
        .i_clk(i_clk), .i_we(nw_we), .i_waddr(nw_waddr), .i_wdata(nw_wdata),
        .i_raddr(nw_raddr), .o_rdata(nw_rdata)
    );
    tspf_ram #(.W(AW), .D(POOL_SLOTS)) u_older (
        .i_clk(i_clk), .i_we(ol_we), .i_waddr(ol_waddr), .i_wdata(ol_wdata),
        .i_raddr(r_cur), .o_rdata(ol_rdata)
    );
    tspf_ram #(.W(AW), .D(POOL_SLOTS)) u_free (
        .i_clk(i_clk), .i_we(fr_we), .i_waddr(fr_waddr), .i_wdata(fr_wdata),
        .i_raddr(r_head), .o_rdata(fr_rdata)
    );
    tspf_ram #(.W(RW), .D(POOL_SLOTS)) u_rec (
        .i_clk(i_clk), .i_we(sr_we), .i_waddr(sr_waddr), .i_wdata(sr_wdata),
        .i_raddr(r_cur), .o_rdata(sr_rdata)
    );

    tspf_fade_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(r_state == tspf_pkg::ST_SW_DSTART),
        .i_colour(r_col[r_ch]), .i_rem(r_rem), .i_len(r_len),
        .o_done(div_done), .o_quot(div_q)
    );

    // spawn record
    always_comb begin
        fade_cap = (r_item.fade_ms > r_item.life_ms) ? r_item.life_ms : r_item.fade_ms;
        spawn_rec.colour = {r_item.alpha_in, r_item.blue_in, r_item.green_in, r_item.red_in};
        if (r_item.life_ms == 16'd0) begin
            spawn_rec.draw   = 1'b1;
            spawn_rec.flen   = '0;
            spawn_rec.fstart = r_item.now_ms;
            spawn_rec.death  = r_item.now_ms + tspf_pkg::DRAW_ONCE_MS;
        end else begin
            spawn_rec.draw   = 1'b0;
            spawn_rec.flen   = fade_cap;
            spawn_rec.fstart = r_item.now_ms + 32'(r_item.life_ms - fade_cap);
            spawn_rec.death  = r_item.now_ms + 32'(r_item.life_ms);
        end
    end

    assign rem_full = sr_rdata.death - r_item.now_ms;
    assign scale    = !sr_rdata.draw && (sr_rdata.fstart < r_item.now_ms)
                    && (sr_rdata.flen != 16'd0) && (rem_full < 32'(sr_rdata.flen));

    always_comb begin
        n_state    = r_state;
        n_item     = r_item;
        n_pend     = r_pend;
        n_pend_vld = r_pend_vld;
        n_out      = r_out;
        n_out_vld  = r_out_vld;
        n_slot     = r_slot;
        n_cur      = r_cur;
        n_head     = r_head;
        n_oldest   = r_oldest;
        n_newest   = r_newest;
        n_count    = r_count;
        n_fresh    = r_fresh;
        n_empty    = r_empty;
        n_ev       = r_ev;
        n_end      = r_end;
        n_rem      = r_rem;
        n_len      = r_len;
        n_col      = r_col;
        n_ch       = r_ch;
        nw_we = 1'b0; nw_waddr = r_newest; nw_wdata = r_slot;
        ol_we = 1'b0; ol_waddr = r_slot;   ol_wdata = r_newest;
        fr_we = 1'b0; fr_waddr = r_cur;    fr_wdata = r_head;
        sr_we = 1'b0; sr_waddr = r_slot;   sr_wdata = spawn_rec;
        nw_raddr = (r_state == tspf_pkg::ST_IDLE) ? r_oldest : r_cur;
        is_old  = (r_cur == r_oldest);
        is_new  = (r_cur == r_newest);
        do_link = 1'b0;

        if (!i_out_stall) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            tspf_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_item = i_in_data;
                    if (i_in_data.kind == tspf_pkg::KIND_SPAWN) begin
                        n_ev    = (r_count == '0);
                        n_slot  = (r_count == '0) ? r_oldest : r_head;
                        n_state = tspf_pkg::ST_SP_LINK;
                    end else begin
                        n_cur   = r_oldest;
                        n_state = r_empty ? tspf_pkg::ST_FLUSH : tspf_pkg::ST_SW_RD;
                    end
                end
            end
            tspf_pkg::ST_SP_LINK: begin
                if (r_ev) begin
                    // the oldest slot is reused; it is never also the newest
                    // unless it is the only live slot
                    do_link  = (r_slot != r_newest);
                    n_oldest = do_link ? nw_rdata : r_slot;
                end else begin
                    do_link  = !r_empty;
                    n_oldest = r_empty ? r_slot : r_oldest;
                    n_count  = r_count - CW'(1);
                    if (CW'(r_slot) == r_fresh) begin
                        n_head  = r_slot + AW'(1);
                        n_fresh = r_fresh + CW'(1);
                    end else begin
                        n_head = fr_rdata;
                    end
                end
                nw_we      = do_link;
                ol_we      = do_link;
                n_newest   = r_slot;
                n_empty    = 1'b0;
                sr_we      = 1'b1;
                n_pend     = '{result_kind: tspf_pkg::KIND_SPAWN,
                               slot: tspf_pkg::SLOT_W'(r_slot), evicted: r_ev,
                               red_out: r_item.red_in, green_out: r_item.green_in,
                               blue_out: r_item.blue_in, alpha_out: r_item.alpha_in,
                               last: 1'b1};
                n_pend_vld = 1'b1;
                n_state    = tspf_pkg::ST_FLUSH;
            end
            tspf_pkg::ST_SW_RD: begin
                n_state = tspf_pkg::ST_SW_EVAL;
            end
            tspf_pkg::ST_SW_EVAL: begin
                n_cur  = nw_rdata;
                n_end  = is_new;
                n_slot = r_cur;
                if (sr_rdata.death <= r_item.now_ms) begin
                    // unlink and push onto the free chain
                    if (is_old) begin
                        n_oldest = nw_rdata;
                    end else begin
                        nw_we    = 1'b1;
                        nw_waddr = ol_rdata;
                        nw_wdata = nw_rdata;
                    end
                    if (is_new) begin
                        n_newest = ol_rdata;
                    end else begin
                        ol_we    = 1'b1;
                        ol_waddr = nw_rdata;
                        ol_wdata = ol_rdata;
                    end
                    n_empty = is_old && is_new;
                    fr_we   = 1'b1;
                    n_head  = r_cur;
                    if (r_count != CW'(POOL_SLOTS)) begin
                        n_count = r_count + CW'(1);
                    end
                    n_state = is_new ? tspf_pkg::ST_FLUSH : tspf_pkg::ST_SW_RD;
                end else begin
                    n_rem = rem_full[15:0];
                    n_len = sr_rdata.flen;
                    n_col = sr_rdata.colour;
                    n_ch  = '0;
                    if (sr_rdata.draw) begin
                        // shown once: expires at the next sweep
                        sr_we          = 1'b1;
                        sr_waddr       = r_cur;
                        sr_wdata       = sr_rdata;
                        sr_wdata.death = r_item.now_ms;
                    end
                    n_state = scale ? tspf_pkg::ST_SW_DSTART : tspf_pkg::ST_SW_PUSH;
                end
            end
            tspf_pkg::ST_SW_DSTART: begin
                n_state = tspf_pkg::ST_SW_DWAIT;
            end
            tspf_pkg::ST_SW_DWAIT: begin
                if (div_done) begin
                    n_col[r_ch] = div_q;
                    n_ch        = r_ch + 2'd1;
                    n_state     = (r_ch == 2'd3) ? tspf_pkg::ST_SW_PUSH
                                                 : tspf_pkg::ST_SW_DSTART;
                end
            end
            tspf_pkg::ST_SW_PUSH: begin
                // a survivor is held back until the next one shows whether it is last
                if (!r_pend_vld || out_free) begin
                    if (r_pend_vld) begin
                        n_out     = r_pend;
                        n_out_vld = 1'b1;
                    end
                    n_pend     = '{result_kind: tspf_pkg::KIND_SWEEP,
                                   slot: tspf_pkg::SLOT_W'(r_slot), evicted: 1'b0,
                                   red_out: r_col[0], green_out: r_col[1],
                                   blue_out: r_col[2], alpha_out: r_col[3],
                                   last: 1'b0};
                    n_pend_vld = 1'b1;
                    n_state    = r_end ? tspf_pkg::ST_FLUSH : tspf_pkg::ST_SW_RD;
                end
            end
            tspf_pkg::ST_FLUSH: begin
                if (!r_pend_vld) begin
                    n_state = tspf_pkg::ST_IDLE;
                end else if (out_free) begin
                    n_out      = r_pend;
                    n_out.last = 1'b1;
                    n_out_vld  = 1'b1;
                    n_pend_vld = 1'b0;
                    n_state    = tspf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tspf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= tspf_pkg::ST_IDLE;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
            r_head     <= '0;
            r_fresh    <= '0;
            r_count    <= CW'(POOL_SLOTS);
            r_empty    <= 1'b1;
            r_oldest   <= '0;
            r_newest   <= '0;
        end else begin
            r_state    <= n_state;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
            r_head     <= n_head;
            r_fresh    <= n_fresh;
            r_count    <= n_count;
            r_empty    <= n_empty;
            r_oldest   <= n_oldest;
            r_newest   <= n_newest;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_pend <= n_pend;
        r_out  <= n_out;
        r_slot <= n_slot;
        r_cur  <= n_cur;
        r_ev   <= n_ev;
        r_end  <= n_end;
        r_rem  <= n_rem;
        r_len  <= n_len;
        r_col  <= n_col;
        r_ch   <= n_ch;
    end

    assign o_in_stall  = (r_state != tspf_pkg::ST_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;
endmodule

### rtl/tspf_checker.sv
// Port-level checks for the slot pool, bound to the top level.
module tspf_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_stall,
    input logic           o_out_valid,
    input logic           i_out_stall,
    input tspf_pkg::t_out o_out_data
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while item in work");

    a_spawn_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.result_kind == tspf_pkg::KIND_SPAWN |-> o_out_data.last)
        else $error("spawn result without last");

    a_sweep_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.result_kind == tspf_pkg::KIND_SWEEP
        |-> !o_out_data.evicted)
        else $error("sweep result flagged evicted");
endmodule

bind timed_slot_pool_with_fade_core tspf_checker u_tspf_checker (.*);

### sim/timed_slot_pool_with_fade_core_tb.sv
// Testbench for the timed slot pool: spawns and fading sweeps checked against a local predictor.
module timed_slot_pool_with_fade_core_tb;

    localparam int NSLOT = 64;
    localparam logic [6:0] NO_SLOT = 7'd64;
    localparam int CYCLE_LIMIT = 3000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    tspf_pkg::t_in i_in_data = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    tspf_pkg::t_out o_out_data;

    timed_slot_pool_with_fade_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data)
    );

    always #10 i_clk = ~i_clk;

    // predictor state
    logic [5:0] p_newer [NSLOT];
    logic [5:0] p_older [NSLOT];
    logic [5:0] p_free_next [NSLOT];
    logic [5:0] p_free_head;
    int unsigned p_free_cnt;
    logic [6:0] p_newest, p_oldest;
    logic [31:0] p_death [NSLOT];
    logic [31:0] p_fstart [NSLOT];
    logic [15:0] p_flen [NSLOT];
    logic [7:0] p_col [NSLOT][4];
    logic p_once [NSLOT];

    tspf_pkg::t_out expected_results[$];
    int errors = 0;
    int spawns_sent = 0, sweeps_sent = 0, results_seen = 0, evictions_seen = 0, faded_seen = 0;
    int sender_idle_pct = 0, recv_idle_pct = 0;
    longint cycles = 0;

    task automatic pool_unlink(input logic [5:0] s);
        logic is_old, is_new;
        logic [5:0] o, n;
        is_old = ({1'b0, s} == p_oldest);
        is_new = ({1'b0, s} == p_newest);
        o = p_older[s];
        n = p_newer[s];
        if (is_old) p_oldest = is_new ? NO_SLOT : {1'b0, n};
        else p_newer[o] = n;
        if (is_new) p_newest = is_old ? NO_SLOT : {1'b0, o};
        else p_older[n] = o;
    endtask

    task automatic pool_predict(input tspf_pkg::t_in it);
        logic [31:0] lifev, fadev, rem, lenv;
        logic [5:0] s;
        logic ev, scale;
        logic [6:0] cur, nxt;
        tspf_pkg::t_out r;
        int k;
        int base;
        if (it.kind == tspf_pkg::KIND_SPAWN) begin
            lifev = {16'd0, it.life_ms};
            fadev = {16'd0, it.fade_ms};
            if (fadev > lifev) fadev = lifev;
            ev = 1'b0;
            if (p_free_cnt != 0) begin
                s = p_free_head;
                p_free_head = p_free_next[s];
                p_free_cnt--;
            end else begin
                s = p_oldest[5:0];
                pool_unlink(s);
                ev = 1'b1;
            end
            if (p_newest == NO_SLOT) p_oldest = {1'b0, s};
            else begin
                p_newer[p_newest[5:0]] = s;
                p_older[s] = p_newest[5:0];
            end
            p_newest = {1'b0, s};
            p_col[s][0] = it.red_in;
            p_col[s][1] = it.green_in;
            p_col[s][2] = it.blue_in;
            p_col[s][3] = it.alpha_in;
            if (lifev == 0) begin
                p_death[s] = it.now_ms + tspf_pkg::DRAW_ONCE_MS;
                p_fstart[s] = it.now_ms;
                p_flen[s] = '0;
                p_once[s] = 1'b1;
            end else begin
                p_death[s] = it.now_ms + lifev;
                p_fstart[s] = it.now_ms + (lifev - fadev);
                p_flen[s] = fadev[15:0];
                p_once[s] = 1'b0;
            end
            r = '{result_kind: tspf_pkg::KIND_SPAWN, slot: s, evicted: ev,
                  red_out: it.red_in, green_out: it.green_in, blue_out: it.blue_in,
                  alpha_out: it.alpha_in, last: 1'b1};
            expected_results.push_back(r);
        end else begin
            base = expected_results.size();
            cur = p_oldest;
            for (k = 0; k < NSLOT && cur != NO_SLOT; k++) begin
                s = cur[5:0];
                nxt = (cur == p_newest) ? NO_SLOT : {1'b0, p_newer[s]};
                if (p_death[s] <= it.now_ms) begin
                    pool_unlink(s);
                    p_free_next[s] = p_free_head;
                    p_free_head = s;
                    if (p_free_cnt < NSLOT) p_free_cnt++;
                end else begin
                    rem = p_death[s] - it.now_ms;
                    lenv = {16'd0, p_flen[s]};
                    scale = !p_once[s] && p_fstart[s] < it.now_ms && lenv != 0 && rem < lenv;
                    r = '0;
                    r.result_kind = tspf_pkg::KIND_SWEEP;
                    r.slot = s;
                    r.red_out = scale ? 8'((64'(p_col[s][0]) * rem) / lenv) : p_col[s][0];
                    r.green_out = scale ? 8'((64'(p_col[s][1]) * rem) / lenv) : p_col[s][1];
                    r.blue_out = scale ? 8'((64'(p_col[s][2]) * rem) / lenv) : p_col[s][2];
                    r.alpha_out = scale ? 8'((64'(p_col[s][3]) * rem) / lenv) : p_col[s][3];
                    if (scale) faded_seen++;
                    if (p_once[s]) p_death[s] = it.now_ms;
                    expected_results.push_back(r);
                end
                cur = nxt;
            end
            if (expected_results.size() > base)
                expected_results[expected_results.size() - 1].last = 1'b1;
        end
    endtask

    task automatic pool_reset_model();
        for (int i = 0; i < NSLOT; i++) begin
            p_free_next[i] = 6'(i + 1);
            p_newer[i] = '0;
            p_older[i] = '0;
        end
        p_free_head = '0;
        p_free_cnt = NSLOT;
        p_newest = NO_SLOT;
        p_oldest = NO_SLOT;
    endtask

    // one transfer on the input channel, with the sender's random gaps
    task automatic send_item(input tspf_pkg::t_in it);
        @(posedge i_clk);
        while ($urandom_range(99, 0) < sender_idle_pct) @(posedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pool_predict(it);
        if (it.kind == tspf_pkg::KIND_SPAWN) spawns_sent++;
        else sweeps_sent++;
        i_in_valid <= 1'b0;
    endtask

    function automatic tspf_pkg::t_in spawn_item(input logic [31:0] now,
                                                 input logic [15:0] life,
                                                 input logic [15:0] fade,
                                                 input logic [31:0] rgba);
        tspf_pkg::t_in it;
        it = '{kind: tspf_pkg::KIND_SPAWN, now_ms: now, life_ms: life, fade_ms: fade,
               red_in: rgba[7:0], green_in: rgba[15:8], blue_in: rgba[23:16],
               alpha_in: rgba[31:24]};
        return it;
    endfunction

    function automatic tspf_pkg::t_in sweep_item(input logic [31:0] now);
        tspf_pkg::t_in it;
        it = '0;
        it.kind = tspf_pkg::KIND_SWEEP;
        it.now_ms = now;
        it.life_ms = 16'($urandom);
        it.fade_ms = 16'($urandom);
        it.red_in = 8'($urandom);
        it.alpha_in = 8'($urandom);
        return it;
    endfunction

    task automatic drain_results();
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    // receiver: random stalls, compare each transfer with the oldest expectation
    always @(posedge i_clk) begin
        tspf_pkg::t_out exp_r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result %p", $time, o_out_data);
            end else begin
                exp_r = expected_results.pop_front();
                if (o_out_data.evicted) evictions_seen++;
                if (o_out_data !== exp_r) begin
                    errors++;
                    $display("%0t: mismatch expected %p actual %p", $time, exp_r, o_out_data);
                end
            end
        end
        i_out_stall <= ($urandom_range(99, 0) < recv_idle_pct);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timed_slot_pool_with_fade_core_tb NOT OK");
            $finish;
        end
    end

    task automatic test_directed();
        send_item(sweep_item(32'd0));                                   // empty pool
        send_item(spawn_item(32'd1000, 16'd0, 16'd50, 32'hFFFFFFFF));   // draw once
        send_item(spawn_item(32'd1000, 16'd1000, 16'd2000, 32'hFF80FF01)); // fade capped
        send_item(spawn_item(32'd1000, 16'hFFFF, 16'd0, 32'h00000000));
        send_item(spawn_item(32'hFFFFFFF0, 16'd500, 16'd400, 32'h55AA55AA)); // wrapped sums
        send_item(sweep_item(32'd1050));
        send_item(sweep_item(32'd1050));                                // draw once now expires
        send_item(sweep_item(32'd1500));                                // mid fade
        send_item(sweep_item(32'd1999));
        send_item(sweep_item(32'hFFFFFFFF));
        send_item(spawn_item(32'd10, 16'd1, 16'd1, 32'h12345678));
        send_item(sweep_item(32'd10));
        send_item(sweep_item(32'd11));
        send_item(sweep_item(32'hFFFFFFFF));
        drain_results();
    endtask

    // overfill the pool so spawns evict the oldest
    task automatic test_eviction();
        for (int i = 0; i < 70; i++)
            send_item(spawn_item(32'(2000 + i), 16'(100 + $urandom_range(200)),
                                 16'($urandom_range(300)), $urandom));
        send_item(sweep_item(32'd2150));
        send_item(sweep_item(32'd5000));
        drain_results();
    endtask

    task automatic test_random(input int n_items, input logic [31:0] t0);
        logic [31:0] now;
        logic [15:0] life;
        now = t0;
        for (int i = 0; i < n_items; i++) begin
            now = now + $urandom_range(40);
            if ($urandom_range(99) < 65) begin
                life = ($urandom_range(9) == 0) ? 16'd0 :
                       ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(600, 1));
                send_item(spawn_item(($urandom_range(29) == 0) ? $urandom : now, life,
                                     ($urandom_range(9) == 0) ? 16'($urandom)
                                                             : 16'($urandom_range(600)),
                                     $urandom));
            end else begin
                send_item(sweep_item(($urandom_range(29) == 0) ? $urandom : now));
            end
            if (i == n_items / 2) drain_results();   // hold off until all results are in
        end
        drain_results();
    endtask

    initial begin
        pool_reset_model();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        sender_idle_pct = 28;
        recv_idle_pct = 71;
        test_directed();
        test_eviction();
        test_random(25, 32'd10000);
        sender_idle_pct = 71;
        recv_idle_pct = 28;
        test_random(25, 32'd50000);
        sender_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(25, 32'd90000);
        $display("Covered %0d spawns and %0d sweeps; %0d results, %0d evictions, %0d faded.",
                 spawns_sent, sweeps_sent, results_seen, evictions_seen, faded_seen);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("timed_slot_pool_with_fade_core_tb OK");
        end else begin
            $display("timed_slot_pool_with_fade_core_tb NOT OK");
        end
        $finish;
    end
endmodule
